/* hw/rtl/modbus_frame_length_checker_defines.svh */
`ifndef MODBUS_FRAME_LENGTH_CHECKER_DEFINES_SVH
`define MODBUS_FRAME_LENGTH_CHECKER_DEFINES_SVH

// same-cycle implication
`define MFLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mflc_pkg.sv */
package mflc_pkg;

  localparam int HDR_LEN_DEF = 1;
  localparam int CRC_LEN_DEF = 2;

  typedef enum logic [1:0] {
    STEP_FUNC,
    STEP_META,
    STEP_DATA
  } step_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_DEV_EXC,
    ST_BAD_EXC,
    ST_FUNC_MISMATCH,
    ST_QTY_MISMATCH,
    ST_LEN_MISMATCH,
    ST_TOO_MANY
  } status_t;

  localparam logic [1:0] CFG_MSG_MODE   = 2'd0;
  localparam logic [1:0] CFG_REQ_FUNC   = 2'd1;
  localparam logic [1:0] CFG_REQ_QTY    = 2'd2;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd3;

  localparam logic       MODE_INDICATION   = 1'b0;
  localparam logic       MSG_MODE_RST      = 1'b1;
  localparam logic [7:0] REQ_FUNC_RST      = 8'd3;
  localparam logic [15:0] REQ_QTY_RST      = 16'd0;
  localparam logic [8:0] MAX_LENGTH_RST    = 9'd256;

  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_READ_EXC_STAT = 8'd7;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
  localparam logic [7:0] FC_REPORT_ID     = 8'd17;
  localparam logic [7:0] FC_MASK_WRITE    = 8'd22;
  localparam logic [7:0] FC_RW_REGS       = 8'd23;

  localparam logic [7:0] EXC_LIMIT = 8'd12;

  typedef struct packed {
    logic        msg_mode;
    logic [7:0]  req_function;
    logic [15:0] req_quantity;
    logic [8:0]  max_frame_length;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  function_code;
    logic [7:0]  exc_code;
    logic [15:0] value_count;
    logic [8:0]  frame_length;
  } result_t;

  function automatic logic [3:0] meta_length(logic mode, logic [7:0] f);
    logic [3:0] n;
    n = 4'd0;
    if (mode == MODE_INDICATION) begin
      if (f <= FC_WRITE_REG) begin
        n = 4'd4;
      end else if (f == FC_WRITE_COILS || f == FC_WRITE_REGS) begin
        n = 4'd5;
      end else if (f == FC_MASK_WRITE) begin
        n = 4'd6;
      end else if (f == FC_RW_REGS) begin
        n = 4'd9;
      end
    end else begin
      if (f == FC_WRITE_COIL || f == FC_WRITE_REG || f == FC_WRITE_COILS ||
          f == FC_WRITE_REGS) begin
        n = 4'd4;
      end else if (f == FC_MASK_WRITE) begin
        n = 4'd6;
      end else begin
        n = 4'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] data_count(logic mode, logic [7:0] f, logic [7:0] c1,
                                            logic [7:0] c5, logic [7:0] c9);
    logic [7:0] n;
    n = 8'd0;
    if (mode == MODE_INDICATION) begin
      if (f == FC_WRITE_COILS || f == FC_WRITE_REGS) begin
        n = c5;
      end else if (f == FC_RW_REGS) begin
        n = c9;
      end
    end else if (f <= FC_READ_INPUT || f == FC_REPORT_ID || f == FC_RW_REGS) begin
      n = c1;
    end
    return n;
  endfunction

endpackage

/* hw/rtl/mflc_cfg_regs.sv */
module mflc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [15:0]       wr_data,
  output mflc_pkg::cfg_t    cfg
);

  mflc_pkg::cfg_t cfg_r;
  mflc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        mflc_pkg::CFG_MSG_MODE:   cfg_nxt.msg_mode         = wr_data[0];
        mflc_pkg::CFG_REQ_FUNC:   cfg_nxt.req_function     = wr_data[7:0];
        mflc_pkg::CFG_REQ_QTY:    cfg_nxt.req_quantity     = wr_data;
        mflc_pkg::CFG_MAX_LENGTH: cfg_nxt.max_frame_length = wr_data[8:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.msg_mode         <= mflc_pkg::MSG_MODE_RST;
      cfg_r.req_function     <= mflc_pkg::REQ_FUNC_RST;
      cfg_r.req_quantity     <= mflc_pkg::REQ_QTY_RST;
      cfg_r.max_frame_length <= mflc_pkg::MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/mflc_frame_check.sv */
module mflc_frame_check #(
  parameter int HDR_LEN = mflc_pkg::HDR_LEN_DEF,
  parameter int CRC_LEN = mflc_pkg::CRC_LEN_DEF
) (
  input  mflc_pkg::cfg_t    cfg,
  input  logic [7:0]        func_byte,
  input  logic [7:0]        count_byte_one,
  input  logic [7:0]        qty_high,
  input  logic [7:0]        qty_low,
  input  logic [8:0]        frame_length,
  output mflc_pkg::status_t status,
  output logic [7:0]        exc_code,
  output logic [15:0]       value_count
);

  localparam logic [17:0] OVERHEAD = 18'(HDR_LEN + CRC_LEN);
  localparam logic [8:0]  EXC_LEN  = 9'(HDR_LEN + 2 + CRC_LEN);

  logic [15:0] q;
  logic [7:0]  rf;
  logic [13:0] coil_bytes;
  logic [17:0] want;
  logic        len_free;
  logic [15:0] req_nb;
  logic [15:0] rsp_nb;

  assign q          = cfg.req_quantity;
  assign rf         = cfg.req_function;
  assign coil_bytes = {1'b0, q[15:3]} + 14'(|q[2:0]);

  always_comb begin
    len_free = 1'b0;
    case (rf)
      mflc_pkg::FC_READ_COILS, mflc_pkg::FC_READ_DISCRETE:
        want = 18'd2 + 18'(coil_bytes);
      mflc_pkg::FC_READ_HOLDING, mflc_pkg::FC_READ_INPUT, mflc_pkg::FC_RW_REGS:
        want = 18'd2 + {1'b0, q, 1'b0};
      mflc_pkg::FC_READ_EXC_STAT: want = 18'd3;
      mflc_pkg::FC_REPORT_ID: begin
        want     = 18'd0;
        len_free = 1'b1;
      end
      mflc_pkg::FC_MASK_WRITE: want = 18'd7;
      default: want = 18'd5;
    endcase
    want = want + OVERHEAD;
  end

  always_comb begin
    case (func_byte)
      mflc_pkg::FC_READ_COILS, mflc_pkg::FC_READ_DISCRETE: begin
        req_nb = 16'(coil_bytes);
        rsp_nb = {8'd0, count_byte_one};
      end
      mflc_pkg::FC_READ_HOLDING, mflc_pkg::FC_READ_INPUT, mflc_pkg::FC_RW_REGS: begin
        req_nb = q;
        rsp_nb = {9'd0, count_byte_one[7:1]};
      end
      mflc_pkg::FC_WRITE_COILS, mflc_pkg::FC_WRITE_REGS: begin
        req_nb = q;
        rsp_nb = {qty_high, qty_low};
      end
      mflc_pkg::FC_REPORT_ID: begin
        req_nb = {8'd0, count_byte_one};
        rsp_nb = {8'd0, count_byte_one};
      end
      default: begin
        req_nb = 16'd1;
        rsp_nb = 16'd1;
      end
    endcase
  end

  always_comb begin
    status      = mflc_pkg::ST_OK;
    exc_code    = 8'd0;
    value_count = 16'd0;
    if (cfg.msg_mode == mflc_pkg::MODE_INDICATION) begin
      status = mflc_pkg::ST_OK;
    end else if (func_byte[7]) begin
      if (frame_length == EXC_LEN && rf == {1'b0, func_byte[6:0]} &&
          count_byte_one < mflc_pkg::EXC_LIMIT) begin
        status   = mflc_pkg::ST_DEV_EXC;
        exc_code = count_byte_one;
      end else begin
        status = mflc_pkg::ST_BAD_EXC;
      end
    end else if (!len_free && {9'd0, frame_length} != want) begin
      status = mflc_pkg::ST_LEN_MISMATCH;
    end else if (func_byte != rf) begin
      status = mflc_pkg::ST_FUNC_MISMATCH;
    end else if (req_nb == rsp_nb) begin
      status      = mflc_pkg::ST_OK;
      value_count = rsp_nb;
    end else begin
      status = mflc_pkg::ST_QTY_MISMATCH;
    end
  end

endmodule

/* hw/rtl/mflc_parser.sv */
module mflc_parser #(
  parameter int HDR_LEN = mflc_pkg::HDR_LEN_DEF,
  parameter int CRC_LEN = mflc_pkg::CRC_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  mflc_pkg::cfg_t    cfg,
  output logic              res_valid,
  output mflc_pkg::result_t res
);

  localparam logic [8:0] POS_FUNC  = 9'(HDR_LEN);
  localparam logic [8:0] POS_CNT1  = 9'(HDR_LEN + 1);
  localparam logic [8:0] POS_QHI   = 9'(HDR_LEN + 3);
  localparam logic [8:0] POS_QLO   = 9'(HDR_LEN + 4);
  localparam logic [8:0] POS_CNT5  = 9'(HDR_LEN + 5);
  localparam logic [8:0] POS_CNT9  = 9'(HDR_LEN + 9);
  localparam logic [8:0] LEFT_INIT = 9'(HDR_LEN + 1);

  mflc_pkg::step_t step_r, step_nxt, base_step;
  logic [8:0] rcv_r, rcv_nxt, base_rcv, rcv_n;
  logic [8:0] left_r, left_nxt, base_left, left_n;
  logic [7:0] func_r, func_nxt, base_func, func_n;
  logic [7:0] c1_r, c1_nxt, base_c1, c1_n;
  logic [7:0] qh_r, qh_nxt, base_qh, qh_n;
  logic [7:0] ql_r, ql_nxt, base_ql, ql_n;
  logic [7:0] c5_r, c5_nxt, base_c5, c5_n;
  logic [7:0] c9_r, c9_nxt, base_c9, c9_n;
  logic       disc_r, disc_nxt, base_disc;

  logic       active;
  logic       take_meta;
  logic       eval_data;
  logic       check;
  logic       reject;
  logic [3:0] meta_n;
  logic [8:0] dl;
  logic       too_big;

  mflc_pkg::status_t chk_status;
  logic [7:0]        chk_exc;
  logic [15:0]       chk_count;

  // frame start restarts the parser before the byte is taken
  always_comb begin
    if (frame_start) begin
      base_step = mflc_pkg::STEP_FUNC;
      base_rcv  = 9'd0;
      base_left = LEFT_INIT;
      base_func = 8'd0;
      base_c1   = 8'd0;
      base_qh   = 8'd0;
      base_ql   = 8'd0;
      base_c5   = 8'd0;
      base_c9   = 8'd0;
      base_disc = 1'b0;
    end else begin
      base_step = step_r;
      base_rcv  = rcv_r;
      base_left = left_r;
      base_func = func_r;
      base_c1   = c1_r;
      base_qh   = qh_r;
      base_ql   = ql_r;
      base_c5   = c5_r;
      base_c9   = c9_r;
      base_disc = disc_r;
    end
  end

  assign func_n = (base_rcv == POS_FUNC) ? rx_byte : base_func;
  assign c1_n   = (base_rcv == POS_CNT1) ? rx_byte : base_c1;
  assign qh_n   = (base_rcv == POS_QHI)  ? rx_byte : base_qh;
  assign ql_n   = (base_rcv == POS_QLO)  ? rx_byte : base_ql;
  assign c5_n   = (base_rcv == POS_CNT5) ? rx_byte : base_c5;
  assign c9_n   = (base_rcv == POS_CNT9) ? rx_byte : base_c9;
  assign rcv_n  = base_rcv + 9'd1;
  assign left_n = base_left - 9'd1;

  assign meta_n  = mflc_pkg::meta_length(cfg.msg_mode, func_n);
  assign dl      = 9'(CRC_LEN) +
                   {1'b0, mflc_pkg::data_count(cfg.msg_mode, func_n, c1_n, c5_n, c9_n)};
  assign too_big = ({1'b0, rcv_n} + {1'b0, dl}) > {1'b0, cfg.max_frame_length};

  always_comb begin
    active    = !base_disc;
    take_meta = 1'b0;
    eval_data = 1'b0;
    check     = 1'b0;
    reject    = 1'b0;
    if (active && left_n == 9'd0) begin
      case (base_step)
        mflc_pkg::STEP_FUNC: begin
          if (meta_n != 4'd0) begin
            take_meta = 1'b1;
          end else begin
            eval_data = 1'b1;
          end
        end
        mflc_pkg::STEP_META: eval_data = 1'b1;
        mflc_pkg::STEP_DATA: check = 1'b1;
        default:             check = 1'b1;
      endcase
      if (eval_data) begin
        if (too_big) begin
          reject = 1'b1;
        end else if (dl == 9'd0) begin
          check = 1'b1;
        end
      end
    end
  end

  always_comb begin
    step_nxt = base_step;
    rcv_nxt  = base_rcv;
    left_nxt = base_left;
    func_nxt = base_func;
    c1_nxt   = base_c1;
    qh_nxt   = base_qh;
    ql_nxt   = base_ql;
    c5_nxt   = base_c5;
    c9_nxt   = base_c9;
    disc_nxt = base_disc;
    if (active) begin
      rcv_nxt  = rcv_n;
      left_nxt = left_n;
      func_nxt = func_n;
      c1_nxt   = c1_n;
      qh_nxt   = qh_n;
      ql_nxt   = ql_n;
      c5_nxt   = c5_n;
      c9_nxt   = c9_n;
      if (take_meta) begin
        step_nxt = mflc_pkg::STEP_META;
        left_nxt = {5'd0, meta_n};
      end
      if (eval_data) begin
        step_nxt = mflc_pkg::STEP_META;
        if (!too_big) begin
          step_nxt = mflc_pkg::STEP_DATA;
          left_nxt = dl;
        end
      end
      if (check || reject) begin
        disc_nxt = 1'b1;
      end
    end
  end

  mflc_frame_check #(
    .HDR_LEN (HDR_LEN),
    .CRC_LEN (CRC_LEN)
  ) u_check (
    .cfg            (cfg),
    .func_byte      (func_n),
    .count_byte_one (c1_n),
    .qty_high       (qh_n),
    .qty_low        (ql_n),
    .frame_length   (rcv_n),
    .status         (chk_status),
    .exc_code       (chk_exc),
    .value_count    (chk_count)
  );

  always_comb begin
    res_valid          = check || reject;
    res.function_code  = func_n;
    res.frame_length   = rcv_n;
    if (reject) begin
      res.status      = mflc_pkg::ST_TOO_MANY;
      res.exc_code    = 8'd0;
      res.value_count = 16'd0;
    end else begin
      res.status      = chk_status;
      res.exc_code    = chk_exc;
      res.value_count = chk_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mflc_pkg::STEP_FUNC;
      rcv_r  <= 9'd0;
      left_r <= LEFT_INIT;
      func_r <= 8'd0;
      c1_r   <= 8'd0;
      qh_r   <= 8'd0;
      ql_r   <= 8'd0;
      c5_r   <= 8'd0;
      c9_r   <= 8'd0;
      disc_r <= 1'b0;
    end else if (en) begin
      step_r <= step_nxt;
      rcv_r  <= rcv_nxt;
      left_r <= left_nxt;
      func_r <= func_nxt;
      c1_r   <= c1_nxt;
      qh_r   <= qh_nxt;
      ql_r   <= ql_nxt;
      c5_r   <= c5_nxt;
      c9_r   <= c9_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

/* hw/rtl/modbus_frame_length_checker.sv */
// Modbus RTU frame length checker.
// Input channel (in_valid/in_ready): one received byte per item, with
// in_frame_start marking the first byte of a frame. Configuration channel
// (cfg_valid/cfg_ready, always ready): index 0 msg_mode, 1 req_function,
// 2 req_quantity, 3 max_frame_length; write only while no frame item is
// in flight.
// Output channel (out_valid/out_ready): one status item per frame, given on
// the byte that ends the frame or on the byte that reveals it is too long.
// Bytes after a finished frame give nothing until the next frame start.
// An accepted item sits in the input register, is parsed from there by the
// combinational parse logic and its result is written to the output register.
// Throughput: one byte per cycle while the output register is empty or
// out_ready is high; the parse is combinational between the two registers.
// Reset: parser waits for the first byte of a frame (frame start optional),
// registers return to confirmation mode, function 3, quantity 0, length 256.
// When out_ready is low the result holds; the input register still takes
// one byte, then in_ready drops until the result is taken.
`include "modbus_frame_length_checker_defines.svh"

module modbus_frame_length_checker #(
  parameter int HDR_LEN = mflc_pkg::HDR_LEN_DEF,
  parameter int CRC_LEN = mflc_pkg::CRC_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_function_code,
  output logic [7:0]  out_exc_code,
  output logic [15:0] out_value_count,
  output logic [8:0]  out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       out_valid_r, out_valid_nxt;
  logic       adv;
  logic       fire;
  logic       res_valid;

  mflc_pkg::cfg_t    cfg;
  mflc_pkg::result_t res;
  mflc_pkg::result_t out_r;

  assign cfg_ready = 1'b1;

  mflc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !adv);
  assign out_valid_nxt = adv ? (fire && res_valid) : out_valid_r;

  mflc_parser #(
    .HDR_LEN (HDR_LEN),
    .CRC_LEN (CRC_LEN)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (fire),
    .rx_byte     (s1_byte_r),
    .frame_start (s1_start_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_function_code = out_r.function_code;
  assign out_exc_code      = out_r.exc_code;
  assign out_value_count   = out_r.value_count;
  assign out_frame_length  = out_r.frame_length;

  `MFLC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !adv, s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r), "input register lost a stalled item")
  `MFLC_ASSERT_SAME(a_exc_zero, clk, rst_n, out_valid_r && out_r.status != mflc_pkg::ST_DEV_EXC, out_r.exc_code == 8'd0, "exception byte set without device exception")
  `MFLC_ASSERT_SAME(a_count_zero, clk, rst_n, out_valid_r && out_r.status != mflc_pkg::ST_OK, out_r.value_count == 16'd0, "value count set on failed frame")
  `MFLC_ASSERT_SAME(a_exc_len, clk, rst_n, out_valid_r && out_r.status == mflc_pkg::ST_DEV_EXC, out_r.frame_length == 9'(HDR_LEN + 2 + CRC_LEN), "device exception with wrong frame length")

endmodule
